// File: rtl/rxrh_pkg.sv
// rxrh_pkg: shared constants and payload types for the ray/rectangle hit pipeline
// no dependencies; used by rxrh_udiv users and the top level ray_xy_rectangle_hit
package rxrh_pkg;

   // default fraction bits of the fixed-point coordinates
   localparam int FracBitsDefault = 16;
   // fraction bits of the texture coordinates
   localparam int TexBits = 16;
   // coordinate width
   localparam int CoordW = 32;
   // csr address width
   localparam int CsrAddrW = 3;

   // register indexes
   typedef enum logic [CsrAddrW-1:0] {
      REG_RECT_X_LOW  = 3'd0,
      REG_RECT_X_HIGH = 3'd1,
      REG_RECT_Y_LOW  = 3'd2,
      REG_RECT_Y_HIGH = 3'd3,
      REG_PLANE_Z     = 3'd4
   } reg_index_type;

   // one ray as it arrives
   typedef struct packed {
      logic signed [CoordW-1:0] far_limit;
      logic signed [CoordW-1:0] near_limit;
      logic signed [CoordW-1:0] dir_z;
      logic signed [CoordW-1:0] dir_y;
      logic signed [CoordW-1:0] dir_x;
      logic signed [CoordW-1:0] origin_z;
      logic signed [CoordW-1:0] origin_y;
      logic signed [CoordW-1:0] origin_x;
   } ray_type;

   // side data carried through the distance divider
   typedef struct packed {
      ray_type ray;
      logic    neg;
      logic    ovf;
      logic    dz_neg;
   } tdiv_pay_type;

   // side data carried through the texture divider
   typedef struct packed {
      logic                     hit;
      logic signed [CoordW-1:0] t;
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic                     front;
      logic                     zero_u;
   } tex_pay_type;

endpackage

// File: rtl/rxrh_udiv.sv
// rxrh_udiv: pipelined unsigned restoring divider, one quotient bit per stage
// standalone; the caller guarantees the starting remainder is below the divisor
module rxrh_udiv #(
   parameter int DW = 32,
   parameter int QW = 32,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [PW-1:0] out_pay
);

   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] nq_ff    [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [PW-1:0] pay_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          src_valid;
      logic [DW-1:0] src_rem;
      logic [QW-1:0] src_nq;
      logic [DW-1:0] src_den;
      logic [PW-1:0] src_pay;
      logic [DW:0]   rem2;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] nq_in;

      // stage input: ports for the first stage, previous stage otherwise
      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_rem;
         assign src_nq    = in_num;
         assign src_den   = in_den;
         assign src_pay   = in_pay;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_nq    = nq_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_pay   = pay_ff[k-1];
      end

      // one trial subtraction; numerator bits leave the top, quotient bits enter below
      always_comb begin
         rem2   = {src_rem, src_nq[QW-1]};
         diff   = rem2 - {1'b0, src_den};
         ge     = ~diff[DW];
         rem_in = ge ? diff[DW-1:0] : rem2[DW-1:0];
         nq_in  = {src_nq[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= nq_in;
            den_ff[k] <= src_den;
            pay_ff[k] <= src_pay;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = nq_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

endmodule

// File: rtl/ray_xy_rectangle_hit.sv
// ray_xy_rectangle_hit: ray against a rectangle in a plane of constant z, fully pipelined
// depends on rxrh_pkg and rxrh_udiv
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  req_tdata: ray, 8 x 32 bit
//   rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata: hit result, 132 bit in 136
//   csr_      in         csr_valid/csr_ready    csr_addr (register), csr_wdata
//
// one ray per cycle unless a blocked result stalls the pipe (distance divider 32 stages,
// texture divider 17 stages, one bit per stage)
// synchronous active-high reset clears valid bits and loads register reset values
// a waiting result stalls the pipe only when the last stage holds an item; bubbles close up
// csr writes are always taken; no ray is taken while reset is high
module ray_xy_rectangle_hit #(
   parameter int FRAC_BITS = rxrh_pkg::FracBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, near_limit, far_limit
   input  logic [255:0]                  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // is_hit, hit_distance, hit_x, hit_y, tex_u, tex_v, front, 4 zero bits
   output logic [135:0]                  rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rxrh_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [31:0]                   csr_wdata
);

   localparam int NMW = 32 + FRAC_BITS;
   localparam int TQW = rxrh_pkg::TexBits + 1;

   // configuration registers
   logic signed [31:0] rect_x_low_ff, rect_x_high_ff, rect_y_low_ff, rect_y_high_ff;
   logic signed [31:0] plane_z_ff;
   logic signed [31:0] x0, x1, y0, y1;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_low_ff  <= '0;
         rect_x_high_ff <= 32'sd1 <<< FRAC_BITS;
         rect_y_low_ff  <= '0;
         rect_y_high_ff <= 32'sd1 <<< FRAC_BITS;
         plane_z_ff     <= '0;
      end else if (csr_valid) begin
         case (rxrh_pkg::reg_index_type'(csr_addr))
            rxrh_pkg::REG_RECT_X_LOW:  rect_x_low_ff  <= csr_wdata;
            rxrh_pkg::REG_RECT_X_HIGH: rect_x_high_ff <= csr_wdata;
            rxrh_pkg::REG_RECT_Y_LOW:  rect_y_low_ff  <= csr_wdata;
            rxrh_pkg::REG_RECT_Y_HIGH: rect_y_high_ff <= csr_wdata;
            rxrh_pkg::REG_PLANE_Z:     plane_z_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ordered bounds
   always_comb begin
      x0 = (rect_x_low_ff < rect_x_high_ff) ? rect_x_low_ff : rect_x_high_ff;
      x1 = (rect_x_low_ff < rect_x_high_ff) ? rect_x_high_ff : rect_x_low_ff;
      y0 = (rect_y_low_ff < rect_y_high_ff) ? rect_y_low_ff : rect_y_high_ff;
      y1 = (rect_y_low_ff < rect_y_high_ff) ? rect_y_high_ff : rect_y_low_ff;
   end

   // pipeline advance: hold only when the last stage has an item the output cannot take
   logic ce;
   logic vu;
   logic out_free;

   assign out_free   = ~rsp_tvalid | rsp_tready;
   assign ce         = ~(vu & ~out_free);
   assign req_tready = ce & ~reset;

   // stage 1: plane distance along z
   rxrh_pkg::ray_type  ray_in;
   logic               v1_ff;
   rxrh_pkg::ray_type  ray1_ff;
   logic signed [32:0] diff1_ff;

   assign ray_in = rxrh_pkg::ray_type'(req_tdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ray1_ff  <= ray_in;
         diff1_ff <= {plane_z_ff[31], plane_z_ff} - {ray_in.origin_z[31], ray_in.origin_z};
      end
   end

   // stage 2: magnitudes, quotient sign and overflow check
   logic [31:0]            abs_diff;
   logic [31:0]            abs_dz;
   logic [NMW-1:0]         nmag;
   logic [31:0]            nmag_hi;
   logic                   v2_ff;
   logic [31:0]            rem2_ff;
   logic [31:0]            num2_ff;
   logic [31:0]            den2_ff;
   rxrh_pkg::tdiv_pay_type pay2_in, pay2_ff;

   always_comb begin
      abs_diff = diff1_ff[32] ? 32'(-diff1_ff) : diff1_ff[31:0];
      abs_dz   = ray1_ff.dir_z[31] ? 32'(-ray1_ff.dir_z) : ray1_ff.dir_z;
      nmag     = {abs_diff, {FRAC_BITS{1'b0}}};
      nmag_hi  = {{(32 - FRAC_BITS){1'b0}}, nmag[NMW-1:32]};
      pay2_in.ray    = ray1_ff;
      pay2_in.neg    = diff1_ff[32] ^ ray1_ff.dir_z[31];
      pay2_in.ovf    = nmag_hi >= abs_dz;
      pay2_in.dz_neg = ray1_ff.dir_z[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ce) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem2_ff <= nmag_hi;
         num2_ff <= nmag[31:0];
         den2_ff <= abs_dz;
         pay2_ff <= pay2_in;
      end
   end

   // distance divider
   logic                   vq;
   logic [31:0]            quo_t;
   rxrh_pkg::tdiv_pay_type payq;

   rxrh_udiv #(
      .DW(32),
      .QW(32),
      .PW($bits(rxrh_pkg::tdiv_pay_type))
   ) u_tdiv (
      .clock    (clock),
      .reset    (reset),
      .en       (ce),
      .in_valid (v2_ff),
      .in_rem   (rem2_ff),
      .in_num   (num2_ff),
      .in_den   (den2_ff),
      .in_pay   (pay2_ff),
      .out_valid(vq),
      .out_quo  (quo_t),
      .out_pay  (payq)
   );

   // stage 3: signed distance and range check
   logic               v3_ff;
   logic signed [31:0] t3_ff;
   logic               ok3_ff;
   rxrh_pkg::ray_type  ray3_ff;
   logic               dzneg3_ff;
   logic               rng_ok;

   assign rng_ok = payq.neg ? (quo_t <= 32'h8000_0000) : (quo_t <= 32'h7fff_ffff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ce) begin
         v3_ff <= vq;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         t3_ff     <= payq.neg ? -quo_t : quo_t;
         ok3_ff    <= ~payq.ovf & rng_ok;
         ray3_ff   <= payq.ray;
         dzneg3_ff <= payq.dz_neg;
      end
   end

   // stage 4: window check and products along x and y
   logic               v4_ff;
   logic signed [63:0] px4_ff, py4_ff;
   logic signed [31:0] t4_ff, ox4_ff, oy4_ff;
   logic               ok4_ff, dzneg4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (ce) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         px4_ff    <= 64'(t3_ff) * 64'(ray3_ff.dir_x);
         py4_ff    <= 64'(t3_ff) * 64'(ray3_ff.dir_y);
         ok4_ff    <= ok3_ff & (t3_ff >= ray3_ff.near_limit) & (t3_ff <= ray3_ff.far_limit);
         t4_ff     <= t3_ff;
         ox4_ff    <= ray3_ff.origin_x;
         oy4_ff    <= ray3_ff.origin_y;
         dzneg4_ff <= dzneg3_ff;
      end
   end

   // stage 5: hit point, floor of the scaled product
   logic               v5_ff;
   logic signed [63:0] x5_ff, y5_ff;
   logic signed [31:0] t5_ff;
   logic               ok5_ff, dzneg5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (ce) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         x5_ff     <= 64'(ox4_ff) + (px4_ff >>> FRAC_BITS);
         y5_ff     <= 64'(oy4_ff) + (py4_ff >>> FRAC_BITS);
         t5_ff     <= t4_ff;
         ok5_ff    <= ok4_ff;
         dzneg5_ff <= dzneg4_ff;
      end
   end

   // stage 6: rectangle test, offsets and spans for the texture coordinates
   logic                  v6_ff;
   logic [31:0]           offx6_ff, offy6_ff, spanx6_ff, spany6_ff;
   logic [63:0]           offx, offy;
   logic                  in_rect;
   rxrh_pkg::tex_pay_type pay6_ff;
   rxrh_pkg::tex_pay_type pay6_in;

   always_comb begin
      offx    = x5_ff - 64'(x0);
      offy    = y5_ff - 64'(y0);
      in_rect = (x5_ff >= 64'(x0)) & (x5_ff <= 64'(x1))
              & (y5_ff >= 64'(y0)) & (y5_ff <= 64'(y1));
      pay6_in.hit    = ok5_ff & in_rect;
      pay6_in.t      = t5_ff;
      pay6_in.x      = x5_ff[31:0];
      pay6_in.y      = y5_ff[31:0];
      pay6_in.front  = dzneg5_ff;
      pay6_in.zero_u = (x1 == x0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (ce) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         offx6_ff  <= offx[31:0];
         offy6_ff  <= offy[31:0];
         spanx6_ff <= 32'(x1 - x0);
         spany6_ff <= 32'(y1 - y0);
         pay6_ff   <= pay6_in;
      end
   end

   // texture dividers, quotient at most one so only TexBits + 1 bits are formed
   rxrh_pkg::tex_pay_type payu;
   logic [TQW-1:0]        quo_u, quo_v;
   logic                  vv_unused_free;
   logic                  zero_v;

   rxrh_udiv #(
      .DW(32),
      .QW(TQW),
      .PW($bits(rxrh_pkg::tex_pay_type))
   ) u_udiv (
      .clock    (clock),
      .reset    (reset),
      .en       (ce),
      .in_valid (v6_ff),
      .in_rem   ({1'b0, offx6_ff[31:1]}),
      .in_num   ({offx6_ff[0], {rxrh_pkg::TexBits{1'b0}}}),
      .in_den   (spanx6_ff),
      .in_pay   (pay6_ff),
      .out_valid(vu),
      .out_quo  (quo_u),
      .out_pay  (payu)
   );

   rxrh_udiv #(
      .DW(32),
      .QW(TQW),
      .PW(1)
   ) u_vdiv (
      .clock    (clock),
      .reset    (reset),
      .en       (ce),
      .in_valid (v6_ff),
      .in_rem   ({1'b0, offy6_ff[31:1]}),
      .in_num   ({offy6_ff[0], {rxrh_pkg::TexBits{1'b0}}}),
      .in_den   (spany6_ff),
      .in_pay   (spany6_ff == '0),
      .out_valid(vv_unused_free),
      .out_quo  (quo_v),
      .out_pay  (zero_v)
   );

   // output register, loaded whenever it is empty or being drained
   logic         rsp_tvalid_ff;
   logic [135:0] rsp_tdata_ff, rsp_tdata_in;
   logic [TQW-1:0] tex_u, tex_v;

   always_comb begin
      tex_u = (payu.hit & ~payu.zero_u) ? quo_u : '0;
      tex_v = (payu.hit & ~zero_v) ? quo_v : '0;
      rsp_tdata_in = '0;
      if (payu.hit) begin
         rsp_tdata_in = {4'b0, payu.front, tex_v, tex_u, payu.y, payu.x, payu.t, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_tvalid_ff <= vu & vv_unused_free;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   // a miss carries an all-zero result
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata == '0)
      else $error("miss result not zero");

   // texture coordinates never exceed one
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[113:97] <= 17'd65536 && rsp_tdata[130:114] <= 17'd65536)
      else $error("texture coordinate above one");

   // both texture lanes stay in step
   a_lanes_step: assert property (@(posedge clock) disable iff (reset)
      vu == vv_unused_free)
      else $error("texture dividers out of step");

   // an input transfer is refused only while a finished item is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> vu && rsp_tvalid && !rsp_tready)
      else $error("input stalled without cause");
`endif

endmodule
